[design/gfr_pkg.sv]
// Package with shared constants and types of the gap-framed record receiver.
`default_nettype none
package gfr_pkg;

    localparam int RECORD_BYTES        = 12;
    localparam int INDEX_W             = $clog2(RECORD_BYTES);
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [15:0] GAP_THRESHOLD_RESET = 16'd312;

    // APB register map: one 32-bit register per word.
    localparam int PADDR_W  = 3;
    localparam logic REG_GAP_THRESHOLD = 1'b0;

    // One queued byte as classified by the front end.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       gap;
    } gfr_entry_t;

    typedef enum logic [2:0] {
        CLS_DISCARD  = 3'd0,
        CLS_START    = 3'd1,
        CLS_CONTINUE = 3'd2,
        CLS_RESTART  = 3'd3,
        CLS_EARLY    = 3'd4
    } byte_class_t;

endpackage
`default_nettype wire

[design/gfr_if.sv]
// Stream interfaces for the byte input channel and the record output channel.
`default_nettype none
interface gfr_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] idle_ticks;

    modport source (output valid, output data_byte, output idle_ticks, input ready);
    modport sink   (input valid, input data_byte, input idle_ticks, output ready);
endinterface

interface gfr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mode;
    logic signed [31:0] value_a;
    logic signed [31:0] ratio_s;
    logic signed [15:0] tooth_count;
    logic [15:0]        error_count;
    logic [15:0]        start_sum;
    logic [15:0]        continue_sum;
    logic [15:0]        restart_sum;
    logic [15:0]        early_sum;

    modport source (output valid, output mode, output value_a, output ratio_s,
                    output tooth_count, output error_count, output start_sum,
                    output continue_sum, output restart_sum, output early_sum,
                    input ready);
    modport sink   (input valid, input mode, input value_a, input ratio_s,
                    input tooth_count, input error_count, input start_sum,
                    input continue_sum, input restart_sum, input early_sum,
                    output ready);
endinterface
`default_nettype wire

[design/gfr_front.sv]
// Front end: threshold register on APB and gap detection of incoming bytes.
`default_nettype none
module gfr_front
    import gfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    gfr_in_if.sink                  in_ch,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output gfr_entry_t              push_entry,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [15:0] threshold_reg;
    logic [15:0] threshold_next;
    logic        hit;

    assign hit    = (paddr[2] == REG_GAP_THRESHOLD);
    assign pready = 1'b1;
    assign prdata = hit ? {16'd0, threshold_reg} : 32'd0;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && hit)
        begin
            threshold_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= GAP_THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // A byte is a gap byte when its idle time reaches the threshold.
    assign push_valid           = in_ch.valid;
    assign in_ch.ready          = push_ready;
    assign push_entry.data_byte = in_ch.data_byte;
    assign push_entry.gap       = (in_ch.idle_ticks >= threshold_reg);

endmodule
`default_nettype wire

[design/gfr_queue.sv]
// Short register queue between the front end and the back end.
`default_nettype none
module gfr_queue
    import gfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire gfr_entry_t  push_entry,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output gfr_entry_t       pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    gfr_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

[design/gfr_back.sv]
// Back end: frame tracking, record assembly, diagnostics and result register.
`default_nettype none
module gfr_back
    import gfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  wire gfr_entry_t  pop_entry,
    gfr_out_if.source        out_ch
);

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(RECORD_BYTES - 1);

    logic               discard_reg, discard_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [15:0]        errors_reg, errors_next;
    logic [15:0]        start_reg, start_next;
    logic [15:0]        cont_reg, cont_next;
    logic [15:0]        restart_reg, restart_next;
    logic [15:0]        early_reg, early_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         record_reg [RECORD_BYTES];
    logic [15:0]        weight;
    logic               pop;
    logic               complete;
    logic               store;
    logic [INDEX_W-1:0] store_index;
    byte_class_t        cls;

    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign pop       = pop_valid && pop_ready;
    assign weight    = 16'd1 << index_reg;

    always_comb
    begin
        if (discard_reg)
        begin
            cls = CLS_DISCARD;
        end
        else if (index_reg == '0)
        begin
            cls = pop_entry.gap ? CLS_START : CLS_EARLY;
        end
        else
        begin
            cls = pop_entry.gap ? CLS_RESTART : CLS_CONTINUE;
        end
    end

    assign complete = (cls == CLS_CONTINUE) && (index_reg == LAST_INDEX);

    always_comb
    begin
        discard_next = discard_reg;
        index_next   = index_reg;
        errors_next  = errors_reg;
        start_next   = start_reg;
        cont_next    = cont_reg;
        restart_next = restart_reg;
        early_next   = early_reg;
        store        = 1'b0;
        store_index  = '0;
        unique case (cls)
            CLS_DISCARD:
            begin
                discard_next = 1'b0;
            end
            CLS_START:
            begin
                start_next = start_reg + 16'd1;
                store      = 1'b1;
                index_next = INDEX_W'(1);
            end
            CLS_CONTINUE:
            begin
                cont_next   = cont_reg + weight;
                store       = 1'b1;
                store_index = index_reg;
                index_next  = index_reg + 1'b1;
            end
            CLS_RESTART:
            begin
                restart_next = restart_reg + weight;
                errors_next  = errors_reg + 16'd1;
                store        = 1'b1;
                index_next   = INDEX_W'(1);
            end
            CLS_EARLY:
            begin
                early_next  = early_reg + 16'd1;
                errors_next = errors_reg + 16'd1;
            end
            default:
            begin
                discard_next = discard_reg;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ch.ready) || (pop && complete);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_reg   <= 1'b1;
            index_reg     <= '0;
            errors_reg    <= '0;
            start_reg     <= '0;
            cont_reg      <= '0;
            restart_reg   <= '0;
            early_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (complete)
                begin
                    // A finished record clears all counters and drops the next byte.
                    discard_reg <= 1'b1;
                    index_reg   <= '0;
                    errors_reg  <= '0;
                    start_reg   <= '0;
                    cont_reg    <= '0;
                    restart_reg <= '0;
                    early_reg   <= '0;
                end
                else
                begin
                    discard_reg <= discard_next;
                    index_reg   <= index_next;
                    errors_reg  <= errors_next;
                    start_reg   <= start_next;
                    cont_reg    <= cont_next;
                    restart_reg <= restart_next;
                    early_reg   <= early_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && store)
        begin
            record_reg[store_index] <= pop_entry.data_byte;
        end
        if (pop && complete)
        begin
            // The last byte is taken straight from the queue entry.
            out_ch.mode         <= {record_reg[1], record_reg[0]};
            out_ch.value_a      <= {record_reg[5], record_reg[4], record_reg[3],
                                    record_reg[2]};
            out_ch.ratio_s      <= {record_reg[9], record_reg[8], record_reg[7],
                                    record_reg[6]};
            out_ch.tooth_count  <= {pop_entry.data_byte, record_reg[10]};
            out_ch.error_count  <= errors_next;
            out_ch.start_sum    <= start_next;
            out_ch.continue_sum <= cont_next;
            out_ch.restart_sum  <= restart_next;
            out_ch.early_sum    <= early_next;
        end
    end

    assign out_ch.valid = out_valid_reg;

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= LAST_INDEX)
        else $error("byte index beyond record length");

    a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && complete) |=> (discard_reg && index_reg == '0 && out_valid_reg))
        else $error("completed record did not clear frame state");

    a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (index_reg == '0 && errors_reg == '0 && cont_reg == '0))
        else $error("counters not clear while a discard is pending");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !pop)
        else $error("queue popped while a stalled result is held");
`endif

endmodule
`default_nettype wire

[design/gap_framed_record_receiver.sv]
// Top level of the gap-framed record receiver: front end, queue and back end.
//
// Usage: each input transaction on in_ch carries one received byte and the idle
// timer ticks seen before it. A byte whose idle time is at or above the
// gap_threshold register (APB address 0, reset value 312) marks a frame start.
// Twelve bytes of one frame form a little-endian record; when the twelfth byte
// is processed one output transaction on out_ch carries mode, value_a, ratio_s,
// tooth_count and the diagnostic counters. All other bytes produce no output.
// After reset and after every completed record the next byte is dropped and
// all counters start from zero.
// Throughput is one byte per cycle while no untaken result is held. The
// front end compares the idle time to the threshold and writes into a small
// register queue; the back end takes one entry per cycle from it unless it
// is stopped. The last byte is first written into the queue; the edge that
// pops it from the queue loads the result register and raises out_ch.valid.
// While the result register holds an untaken result the back end stops, the
// queue fills and in_ch.ready falls once it is full; in_ch.ready never depends
// on out_ch.ready combinationally. Reset empties the queue, clears the result
// valid and sets the threshold back to its reset value.
`default_nettype none
module gap_framed_record_receiver
    import gfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    gfr_in_if.sink                  in_ch,
    gfr_out_if.source               out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Handshake between the front end and the queue.
    logic       push_valid;
    logic       push_ready;
    gfr_entry_t push_entry;

    // Handshake between the queue and the back end.
    logic       pop_valid;
    logic       pop_ready;
    gfr_entry_t pop_entry;

    gfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    gfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire
